// ===== rtl/esort_pkg.sv =====
`default_nettype none

package esort_pkg;

  // Width of one element of a set.
  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] elem_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH_I,
    S_LOAD_I,
    S_CMP,
    S_WB,
    S_EMIT_RD,
    S_EMIT_LD
  } esort_state_t;

  // Request from the sequencer to load the output register.
  typedef struct packed {
    logic load;
    logic last;
    logic overflow;
  } emit_t;

endpackage

`default_nettype wire

// ===== rtl/esort_mem.sv =====
`default_nettype none

module esort_mem
  import esort_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire elem_t         wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output elem_t              rdata
);

  // Element store: one write port, one read port with registered data.
  // The read data holds until the next read is issued.
  elem_t mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/esort_seq.sv =====
`default_nettype none

module esort_seq
  import esort_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 64,
  parameter int unsigned AW           = 6,
  parameter int unsigned CW           = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire elem_t         in_data,
  input  wire logic          in_last,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output elem_t              mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  wire elem_t         mem_rdata,
  input  wire logic          out_free,
  output emit_t              emit
);

  esort_state_t  state_r, state_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          drop_r, drop_nxt;
  elem_t         min_r, min_nxt;

  logic [CW-1:0] n_acc;
  logic [CW-1:0] last_idx;
  logic          less;

  assign last_idx = n_r - CW'(1);
  // The shared compare: the element just read against the running minimum.
  assign less     = mem_rdata < min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      cnt_r   <= '0;
      n_r     <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      drop_r  <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    min_r <= min_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    drop_nxt  = drop_r;
    min_nxt   = min_r;
    n_acc     = cnt_r;
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = i_r;
    mem_wdata = min_r;
    mem_re    = 1'b0;
    mem_raddr = i_r;
    emit      = '0;

    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (cnt_r == CW'(MAX_ELEMENTS)) begin
            drop_nxt = 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = cnt_r[AW-1:0];
            mem_wdata = in_data;
            cnt_nxt   = cnt_r + CW'(1);
            n_acc     = cnt_r + CW'(1);
          end
          if (in_last) begin
            n_nxt = n_acc;
            i_nxt = '0;
            if (n_acc < CW'(2)) begin
              state_nxt = S_EMIT_RD;
            end else begin
              state_nxt = S_FETCH_I;
            end
          end
        end
      end

      S_FETCH_I: begin
        mem_re    = 1'b1;
        mem_raddr = i_r;
        state_nxt = S_LOAD_I;
      end

      S_LOAD_I: begin
        min_nxt   = mem_rdata;
        j_nxt     = i_r + AW'(1);
        mem_re    = 1'b1;
        mem_raddr = i_r + AW'(1);
        state_nxt = S_CMP;
      end

      S_CMP: begin
        // Position i lives in min_r during the pass; a smaller later value
        // trades places with it.
        if (less) begin
          mem_we    = 1'b1;
          mem_waddr = j_r;
          mem_wdata = min_r;
          min_nxt   = mem_rdata;
        end
        if (CW'(j_r) == last_idx) begin
          state_nxt = S_WB;
        end else begin
          j_nxt     = j_r + AW'(1);
          mem_re    = 1'b1;
          mem_raddr = j_r + AW'(1);
        end
      end

      S_WB: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = min_r;
        if ((CW'(i_r) + CW'(1)) == last_idx) begin
          i_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          i_nxt     = i_r + AW'(1);
          mem_re    = 1'b1;
          mem_raddr = i_r + AW'(1);
          state_nxt = S_LOAD_I;
        end
      end

      S_EMIT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = i_r;
        state_nxt = S_EMIT_LD;
      end

      S_EMIT_LD: begin
        if (out_free) begin
          emit.load     = 1'b1;
          emit.last     = (CW'(i_r) == last_idx);
          emit.overflow = drop_r;
          if (CW'(i_r) == last_idx) begin
            i_nxt     = '0;
            j_nxt     = '0;
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + AW'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/exchange_sort_engine_core.sv =====
// Exchange sort engine.
// Input channel (in_valid, in_stall, in_data_in, in_last_in): one signed
// 32-bit element per item, buffered until an item with in_last_in set
// closes the set. Elements arriving while the buffer already holds
// MAX_ELEMENTS entries are dropped; every result of that set carries out_overflow.
// Once the set is closed the block sorts it with one shared signed compare
// over an element memory with one write and one read port: a fetch step,
// then for each outer position i a load step, a compare step for each later
// position j and a write-back step.
// Results (out_valid, out_stall, out_data_out, out_last_out, out_overflow)
// then leave in ascending signed order; each is read from the registered
// memory in S_EMIT_RD and loaded into the output register in S_EMIT_LD.
// out_last_out marks the final result of a set.
// in_stall is high from the closing item until the last result is loaded
// into the output register; the next set may start while it waits.
// A stalled result holds in the output register and the sequencer waits.
// Reset (rst_n, synchronous, active low) empties the buffer and clears the
// output register valid; the element memory itself is not cleared.
`default_nettype none

module exchange_sort_engine_core
  import esort_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_data_in,
  input  wire logic        in_last_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_data_out,
  output logic             out_last_out,
  output logic             out_overflow
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  elem_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  elem_t         mem_rdata;
  emit_t         emit;
  logic          out_free;

  // Output register state.
  logic          out_valid_r;
  elem_t         out_data_r;
  logic          out_last_r;
  logic          out_ovf_r;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  esort_seq #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .AW           (AW),
    .CW           (CW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (elem_t'(in_data_in)),
    .in_last   (in_last_in),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_free  (out_free),
    .emit      (emit)
  );

  esort_mem #(
    .DEPTH (MAX_ELEMENTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Valid flag of the output register: set on a load, cleared when the
  // receiver takes the item and nothing new replaces it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload of the output register; it only changes on a load.
  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_data_r <= mem_rdata;
      out_last_r <= emit.last;
      out_ovf_r  <= emit.overflow;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = 32'(out_data_r);
  assign out_last_out = out_last_r;
  assign out_overflow = out_ovf_r;

endmodule

`default_nettype wire

// ===== tb/esort_checker.sv =====
`default_nettype none

module esort_checker
  import esort_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         in_stall,
  input  wire elem_t        in_data_in,
  input  wire logic         in_last_in,
  input  wire logic         out_valid,
  input  wire logic         out_stall,
  input  wire elem_t        out_data_out,
  input  wire logic         out_last_out,
  input  wire logic         out_overflow,
  output int unsigned       fail_count,
  output int unsigned       pending
);

  typedef struct packed {
    elem_t data;
    logic  is_last;
    logic  ovf;
  } sorted_elem_t;

  // Elements of the set being collected, and the sorted results still owed.
  elem_t        set_buf[$];
  logic         set_dropped;
  sorted_elem_t sorted_q[$];
  int unsigned  fails;

  initial begin
    fail_count = 0;
    pending    = 0;
    fails      = 0;
    set_dropped = 1'b0;
  end

  always @(posedge clk) begin : watch
    sorted_elem_t got;
    sorted_elem_t want;
    sorted_elem_t item;
    elem_t        swap;
    int           n;

    if (!rst_n) begin
      set_buf.delete();
      sorted_q.delete();
      set_dropped = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{data: out_data_out, is_last: out_last_out, ovf: out_overflow};
        if (sorted_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("unexpected result: data %0d last %0b overflow %0b",
                     got.data, got.is_last, got.ovf);
          end
        end else begin
          want = sorted_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: expected data %0d last %0b overflow %0b, got data %0d last %0b overflow %0b",
                       want.data, want.is_last, want.ovf, got.data, got.is_last, got.ovf);
            end
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (set_buf.size() < MAX_ELEMENTS) begin
          set_buf.push_back(in_data_in);
        end else begin
          set_dropped = 1'b1;
        end
        if (in_last_in) begin
          n = set_buf.size();
          // Exchange sort: the later entry moves forward when it is smaller.
          for (int i = 0; i + 1 < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
              if (set_buf[j] < set_buf[i]) begin
                swap       = set_buf[i];
                set_buf[i] = set_buf[j];
                set_buf[j] = swap;
              end
            end
          end
          for (int k = 0; k < n; k++) begin
            item = '{data: set_buf[k], is_last: (k == n - 1), ovf: set_dropped};
            sorted_q.push_back(item);
          end
          set_buf.delete();
          set_dropped = 1'b0;
        end
      end
    end

    pending    <= sorted_q.size();
    fail_count <= fails;
  end

endmodule

`default_nettype wire

// ===== tb/tb_exchange_sort_engine_core.sv =====
`default_nettype none

module tb_exchange_sort_engine_core;
  import esort_pkg::*;

  localparam int unsigned DEPTH          = 64;
  // Items to send in total, and the point after which both sides stop idling.
  localparam int unsigned TOTAL_ITEMS    = 260;
  localparam int unsigned QUIET_FROM     = 220;
  // A full set of 64 sorts with nothing accepted on either side, so the
  // watchdog limit is set well above the length of that sort.
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  // Cycles to linger once every result has come, to catch stray outputs.
  localparam int unsigned TAIL_CYCLES    = 64;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_data_in = '0;
  logic        in_last_in = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_data_out;
  logic        out_last_out;
  logic        out_overflow;

  int unsigned fail_count;
  int unsigned pending;

  // Knobs for the idling on both sides. While quiet is set neither side
  // idles; calm gives stretches of a set or so without idling.
  logic        quiet = 1'b0;
  logic        calm = 1'b0;
  int unsigned items_sent = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;

  exchange_sort_engine_core #(
    .MAX_ELEMENTS(DEPTH)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_in   (in_data_in),
    .in_last_in   (in_last_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out),
    .out_last_out (out_last_out),
    .out_overflow (out_overflow)
  );

  esort_checker #(
    .MAX_ELEMENTS(DEPTH)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_in   (in_data_in),
    .in_last_in   (in_last_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out),
    .out_last_out (out_last_out),
    .out_overflow (out_overflow),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The result side stalls in bursts of random length. A burst starts at
  // random whenever neither quiet nor a calm stretch is set.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // The watchdog ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL exchange_sort_engine_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Values lean toward the extremes and toward small numbers, so that
  // duplicates and sign boundaries come up often in the sorted sets.
  function automatic elem_t pick_value();
    int unsigned r;
    r = $urandom_range(0, 7);
    case (r)
      0: begin
        case ($urandom_range(0, 3))
          0: return elem_t'(32'h8000_0000);
          1: return elem_t'(32'h7FFF_FFFF);
          2: return elem_t'(32'h0000_0000);
          default: return elem_t'(32'hFFFF_FFFF);
        endcase
      end
      1: return elem_t'($urandom_range(0, 8)) - elem_t'(4);
      default: return elem_t'($urandom);
    endcase
  endfunction

  // Presents one item and returns at the edge where it is accepted. An idle
  // burst may come first; valid is only lowered in the step where the
  // previous item was taken, and raised again in a later step.
  task automatic send_item(input elem_t value, input logic is_last);
    if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data_in <= value;
    in_last_in <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Holds the sender off until every result owed so far has arrived. The
  // first edge lets the checker account for the item just accepted.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Sends a set of n random elements; the final one closes the set.
  task automatic send_set(input int unsigned n);
    calm = ($urandom_range(0, 3) == 0);
    for (int unsigned k = 0; k < n; k++) begin
      send_item(pick_value(), k == n - 1);
    end
  endtask

  initial begin : stimulus
    int unsigned set_size;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // A set of a single element, at the most negative value.
    send_item(elem_t'(32'h8000_0000), 1'b1);
    // Both extremes, zero, plus and minus one, and alternating bit patterns.
    send_item(elem_t'(32'h7FFF_FFFF), 1'b0);
    send_item(elem_t'(32'h8000_0000), 1'b0);
    send_item(elem_t'(32'h0000_0000), 1'b0);
    send_item(elem_t'(32'hFFFF_FFFF), 1'b0);
    send_item(elem_t'(32'h0000_0001), 1'b0);
    send_item(elem_t'(32'h5555_5555), 1'b0);
    send_item(elem_t'(32'hAAAA_AAAA), 1'b1);
    // Equal values must come out side by side.
    send_item(elem_t'(5), 1'b0);
    send_item(-elem_t'(2), 1'b0);
    send_item(elem_t'(5), 1'b0);
    send_item(elem_t'(5), 1'b0);
    send_item(-elem_t'(2), 1'b1);
    // A set that is already in order, then one in reverse order.
    send_item(-elem_t'(3), 1'b0);
    send_item(elem_t'(0), 1'b0);
    send_item(elem_t'(9), 1'b1);
    send_item(elem_t'(100), 1'b0);
    send_item(elem_t'(50), 1'b0);
    send_item(-elem_t'(50), 1'b0);
    send_item(-elem_t'(100), 1'b1);
    // A single element at the most positive value.
    send_item(elem_t'(32'h7FFF_FFFF), 1'b1);
    wait_drained();

    // Buffer boundary: a set that exactly fills the buffer, one whose closing
    // item is dropped, and one with several dropped elements.
    send_set(DEPTH);
    send_set(DEPTH + 1);
    wait_drained();
    send_set(DEPTH + 3);

    // Random sets, mostly small. Large ones only early, to bound the run.
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= QUIET_FROM) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: set_size = $urandom_range(1, 8);
        7, 8: set_size = $urandom_range(9, 24);
        default: set_size = (items_sent < 150) ? $urandom_range(DEPTH - 2, DEPTH + 2)
                                               : $urandom_range(2, 6);
      endcase
      send_set(set_size);
      // Sometimes let the block drain completely before the next set.
      if (!quiet && $urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS exchange_sort_engine_core");
    end else begin
      $display("FAIL exchange_sort_engine_core");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/esort_pkg.sv
rtl/esort_mem.sv
rtl/esort_seq.sv
rtl/exchange_sort_engine_core.sv
tb/esort_checker.sv
tb/tb_exchange_sort_engine_core.sv
